// File: design/scg_pkg.sv
// ----------------------------------------------------------------------------
// scg_pkg
// Shared types and constants for the store code generator.
// ----------------------------------------------------------------------------
package scg_pkg;

    localparam int PAGE_BYTES = 256;
    localparam logic [8:0] PAGE_LIMIT = 9'(PAGE_BYTES);

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] OP_LDX_IMM = 8'hA2;
    localparam logic [7:0] OP_STX_ABS = 8'h8E;
    localparam logic [7:0] OP_LDY_IMM = 8'hA0;
    localparam logic [7:0] OP_STY_ABS = 8'h8C;
    localparam logic [7:0] OP_LDA_IMM = 8'hA9;
    localparam logic [7:0] OP_STA_ABS = 8'h8D;
    localparam logic [7:0] OP_RTS     = 8'h60;
    localparam logic [7:0] X_VALUE    = 8'h00;
    localparam logic [7:0] Y_VALUE    = 8'h80;

    // one classified data byte, ready to be serialized
    typedef struct packed {
        logic        has_load;
        logic [7:0]  load_op;
        logic [7:0]  load_val;
        logic [7:0]  store_op;
        logic [15:0] addr;
        logic        rts;
    } scg_cmd_t;

    typedef enum logic [2:0] {
        STEP_LOAD_OP  = 3'd0,
        STEP_LOAD_VAL = 3'd1,
        STEP_STORE_OP = 3'd2,
        STEP_ADDR_LO  = 3'd3,
        STEP_ADDR_HI  = 3'd4,
        STEP_RTS      = 3'd5
    } scg_step_t;

endpackage

// File: design/scg_front.sv
// ----------------------------------------------------------------------------
// scg_front
// Accepts data beats, tracks address and register-load state, and turns each
// byte into one command for the serializer.
// ----------------------------------------------------------------------------
module scg_front
    import scg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        block_start,
    input  logic [15:0] start_address,
    output logic        push,
    output scg_cmd_t    push_cmd,
    input  logic        queue_full
);

    logic [15:0] addr_reg, addr_next;
    logic        x_loaded_reg, x_loaded_next;
    logic        y_loaded_reg, y_loaded_next;
    logic        acc_valid_reg, acc_valid_next;
    logic [7:0]  acc_value_reg, acc_value_next;
    logic [7:0]  page_count_reg, page_count_next;

    logic [15:0] addr_eff;
    logic        x_eff, y_eff, acc_valid_eff;
    logic [7:0]  page_eff;
    logic        x_new, y_new, acc_valid_new;
    logic [7:0]  acc_value_new;
    logic        page_done;

    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

    always_comb
    begin
        addr_eff      = block_start ? start_address : addr_reg;
        x_eff         = block_start ? 1'b0 : x_loaded_reg;
        y_eff         = block_start ? 1'b0 : y_loaded_reg;
        acc_valid_eff = block_start ? 1'b0 : acc_valid_reg;
        page_eff      = block_start ? 8'd0 : page_count_reg;

        x_new         = x_eff;
        y_new         = y_eff;
        acc_valid_new = acc_valid_eff;
        acc_value_new = acc_value_reg;

        push_cmd.addr = addr_eff;
        if (data_byte == X_VALUE)
        begin
            push_cmd.has_load = !x_eff;
            push_cmd.load_op  = OP_LDX_IMM;
            push_cmd.load_val = X_VALUE;
            push_cmd.store_op = OP_STX_ABS;
            x_new             = 1'b1;
        end
        else if (data_byte == Y_VALUE)
        begin
            push_cmd.has_load = !y_eff;
            push_cmd.load_op  = OP_LDY_IMM;
            push_cmd.load_val = Y_VALUE;
            push_cmd.store_op = OP_STY_ABS;
            y_new             = 1'b1;
        end
        else
        begin
            push_cmd.has_load = !acc_valid_eff || (acc_value_reg != data_byte);
            push_cmd.load_op  = OP_LDA_IMM;
            push_cmd.load_val = data_byte;
            push_cmd.store_op = OP_STA_ABS;
            acc_valid_new     = 1'b1;
            acc_value_new     = data_byte;
        end

        page_done     = ({1'b0, page_eff} + 9'd1) >= PAGE_LIMIT;
        push_cmd.rts  = page_done;

        addr_next = addr_eff + 16'd1;
        if (page_done)
        begin
            page_count_next = 8'd0;
            x_loaded_next   = 1'b0;
            y_loaded_next   = 1'b0;
            acc_valid_next  = 1'b0;
            acc_value_next  = 8'd0;
        end
        else
        begin
            page_count_next = page_eff + 8'd1;
            x_loaded_next   = x_new;
            y_loaded_next   = y_new;
            acc_valid_next  = acc_valid_new;
            acc_value_next  = acc_value_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg       <= '0;
            x_loaded_reg   <= 1'b0;
            y_loaded_reg   <= 1'b0;
            acc_valid_reg  <= 1'b0;
            acc_value_reg  <= '0;
            page_count_reg <= '0;
        end
        else if (push)
        begin
            addr_reg       <= addr_next;
            x_loaded_reg   <= x_loaded_next;
            y_loaded_reg   <= y_loaded_next;
            acc_valid_reg  <= acc_valid_next;
            acc_value_reg  <= acc_value_next;
            page_count_reg <= page_count_next;
        end
    end

endmodule

// File: design/scg_queue.sv
// ----------------------------------------------------------------------------
// scg_queue
// Small command FIFO between the classifier and the serializer.
// ----------------------------------------------------------------------------
module scg_queue
    import scg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  scg_cmd_t push_cmd,
    output logic     full,
    input  logic     pop,
    output scg_cmd_t head_cmd,
    output logic     empty
);

    scg_cmd_t                 entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0]   count_reg, count_next;

    assign full     = count_reg == QUEUE_CNT_W'(QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign head_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: design/scg_back.sv
// ----------------------------------------------------------------------------
// scg_back
// Serializes queued commands into code bytes, one per cycle unless out_stall
// holds the output or the queue is empty, through an output register.
// ----------------------------------------------------------------------------
module scg_back
    import scg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  scg_cmd_t   head_cmd,
    input  logic       empty,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] code_byte,
    output logic       run_last,
    output logic       page_end
);

    logic [2:0]  step_reg, step_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  code_byte_reg, code_byte_next;
    logic        run_last_reg, run_last_next;
    logic        page_end_reg, page_end_next;

    logic        advance;
    logic        emit;
    logic        last;
    scg_step_t   step_cur;

    assign advance = !out_valid_reg || !out_stall;
    assign emit    = advance && !empty;
    assign pop     = emit && last;

    always_comb
    begin
        step_cur = scg_step_t'(step_reg + (head_cmd.has_load ? 3'd0 : 3'd2));
        last     = (step_cur == STEP_RTS) || ((step_cur == STEP_ADDR_HI) && !head_cmd.rts);

        case (step_cur)
            STEP_LOAD_OP:  code_byte_next = head_cmd.load_op;
            STEP_LOAD_VAL: code_byte_next = head_cmd.load_val;
            STEP_STORE_OP: code_byte_next = head_cmd.store_op;
            STEP_ADDR_LO:  code_byte_next = head_cmd.addr[7:0];
            STEP_ADDR_HI:  code_byte_next = head_cmd.addr[15:8];
            STEP_RTS:      code_byte_next = OP_RTS;
            default:       code_byte_next = OP_RTS;
        endcase
        run_last_next = last;
        page_end_next = step_cur == STEP_RTS;

        if (emit)
        begin
            out_valid_next = 1'b1;
            step_next      = last ? 3'd0 : step_reg + 3'd1;
        end
        else
        begin
            out_valid_next = advance ? 1'b0 : out_valid_reg;
            step_next      = step_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            code_byte_reg <= code_byte_next;
            run_last_reg  <= run_last_next;
            page_end_reg  <= page_end_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign code_byte = code_byte_reg;
    assign run_last  = run_last_reg;
    assign page_end  = page_end_reg;

endmodule

// File: design/store_code_generator.sv
// ----------------------------------------------------------------------------
// store_code_generator
// Turns block data bytes into 6502 store code, one code byte per beat.
// ----------------------------------------------------------------------------
// Each input beat yields 3 to 6 output beats (load pair when needed, store
// opcode, address low and high, RTS at page end). The output side delivers
// one code byte per cycle unless out_stall holds it or the queue is empty,
// so the output serializer sets the throughput. The input side takes one
// beat per cycle while the four-entry command queue has room; the first
// code byte of a beat passes through the queue and then the output register.
module store_code_generator
    import scg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        block_start,
    input  logic [15:0] start_address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  code_byte,
    output logic        run_last,
    output logic        page_end
);

    logic     push;
    logic     pop;
    logic     queue_full;
    logic     queue_empty;
    scg_cmd_t push_cmd;
    scg_cmd_t head_cmd;

    scg_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .block_start   (block_start),
        .start_address (start_address),
        .push          (push),
        .push_cmd      (push_cmd),
        .queue_full    (queue_full)
    );

    scg_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (queue_full),
        .pop      (pop),
        .head_cmd (head_cmd),
        .empty    (queue_empty)
    );

    scg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_cmd  (head_cmd),
        .empty     (queue_empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .code_byte (code_byte),
        .run_last  (run_last),
        .page_end  (page_end)
    );

endmodule

// File: tb/store_code_generator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// store_code_generator_tb
// Drives data bytes into the store code generator and checks every code beat
// against expected 6502 store code from the table or a cycle-free model. A
// short table covers load sharing, block starts, address wrap and extreme
// addresses; a random run with occasional block starts follows. Both ports
// idle at random, with one long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module store_code_generator_tb;
    import scg_pkg::*;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
        logic       pend;
    } code_beat_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        bs;
        logic [15:0] addr;
        logic [2:0]  n;
        logic [47:0] codes;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        block_start;
    logic [15:0] start_address;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  code_byte;
    logic        run_last;
    logic        page_end;

    // generator state as seen from outside
    logic [15:0] tgt_addr;
    logic        x_ld;
    logic        y_ld;
    logic        a_ok;
    logic [7:0]  a_val;
    int          page_cnt;

    code_beat_t  code_expect[$];
    code_beat_t  new_beats[$];
    int          mismatches;
    int          items_taken;
    int          burst_left;
    logic [7:0]  last_imm;
    dir_row_t    dir_rows[25];

    store_code_generator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .block_start  (block_start),
        .start_address(start_address),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .code_byte    (code_byte),
        .run_last     (run_last),
        .page_end     (page_end)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic void clear_loads();
        x_ld  = 1'b0;
        y_ld  = 1'b0;
        a_ok  = 1'b0;
        a_val = 8'h00;
    endfunction

    function automatic void put_beat(input logic [7:0] code, input logic pend);
        new_beats.push_back('{code, 1'b0, pend});
    endfunction

    function automatic void gen_store_code(input logic [7:0] data, input logic bs,
                                           input logic [15:0] addr);
        logic [7:0] store_op;
        new_beats.delete();
        if (bs)
        begin
            tgt_addr = addr;
            page_cnt = 0;
            clear_loads();
        end
        if (data == X_VALUE)
        begin
            if (!x_ld)
            begin
                x_ld = 1'b1;
                put_beat(OP_LDX_IMM, 1'b0);
                put_beat(X_VALUE, 1'b0);
            end
            store_op = OP_STX_ABS;
        end
        else if (data == Y_VALUE)
        begin
            if (!y_ld)
            begin
                y_ld = 1'b1;
                put_beat(OP_LDY_IMM, 1'b0);
                put_beat(Y_VALUE, 1'b0);
            end
            store_op = OP_STY_ABS;
        end
        else
        begin
            if (!a_ok || a_val != data)
            begin
                a_ok  = 1'b1;
                a_val = data;
                put_beat(OP_LDA_IMM, 1'b0);
                put_beat(data, 1'b0);
            end
            store_op = OP_STA_ABS;
        end
        put_beat(store_op, 1'b0);
        put_beat(tgt_addr[7:0], 1'b0);
        put_beat(tgt_addr[15:8], 1'b0);
        tgt_addr = tgt_addr + 16'd1;
        if (page_cnt + 1 >= PAGE_BYTES)
        begin
            put_beat(OP_RTS, 1'b1);
            page_cnt = 0;
            clear_loads();
        end
        else
        begin
            page_cnt = page_cnt + 1;
        end
        new_beats[new_beats.size() - 1].last = 1'b1;
    endfunction

    // mostly X/Y values and repeats of the last immediate, so loads get reused
    function automatic logic [7:0] pick_data();
        logic [7:0] d;
        case ($urandom_range(0, 9))
            0, 1, 2: d = X_VALUE;
            3, 4:    d = Y_VALUE;
            5, 6:    d = last_imm;
            default: d = 8'($urandom_range(0, 255));
        endcase
        if (d != X_VALUE && d != Y_VALUE)
            last_imm = d;
        return d;
    endfunction

    task automatic offer(input logic [7:0] data, input logic bs, input logic [15:0] addr,
                         input logic [2:0] n, input logic [47:0] codes);
        int gap;
        in_valid      <= 1'b1;
        data_byte     <= data;
        block_start   <= bs;
        start_address <= addr;
        do
            @(posedge clk);
        while (in_stall);
        items_taken++;
        gen_store_code(data, bs, addr);
        if (n != 0)
        begin
            for (int i = 0; i < n; i++)
                code_expect.push_back('{codes[47 - 8 * i -: 8], i == n - 1, 1'b0});
        end
        else
        begin
            foreach (new_beats[i])
                code_expect.push_back(new_beats[i]);
        end
        if (burst_left == 0)
        begin
            gap        = $urandom_range(1, 8);
            burst_left = $urandom_range(1, 16);
            in_valid  <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        else
        begin
            burst_left--;
        end
    endtask

    always @(posedge clk)
    begin : check_out
        code_beat_t exp_beat;
        if (rst_n && out_valid && !out_stall)
        begin
            if (code_expect.size() == 0)
            begin
                $error("code beat %h with nothing expected", code_byte);
                mismatches++;
            end
            else
            begin
                exp_beat = code_expect.pop_front();
                if (code_byte !== exp_beat.code)
                begin
                    $error("code_byte: expected %h, got %h", exp_beat.code, code_byte);
                    mismatches++;
                end
                if (run_last !== exp_beat.last)
                begin
                    $error("run_last: expected %b, got %b", exp_beat.last, run_last);
                    mismatches++;
                end
                if (page_end !== exp_beat.pend)
                begin
                    $error("page_end: expected %b, got %b", exp_beat.pend, page_end);
                    mismatches++;
                end
            end
        end
    end

    // output stall patterns, plus one long hold-off
    initial
    begin
        int  len;
        int  mode;
        logic held;
        held = 1'b0;
        out_stall = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (!held && items_taken >= 40)
            begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (150) @(posedge clk);
            end
            mode = $urandom_range(0, 3);
            len  = $urandom_range(5, 40);
            for (int i = 0; i < len; i++)
            begin
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= 1'($urandom_range(0, 1));
                    2:       out_stall <= 1'(i % 2);
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        logic [7:0]  d;
        logic [15:0] a;
        dir_rows = '{
            '{X_VALUE, 1'b0, 16'h0000, 3'd5,
              {OP_LDX_IMM, X_VALUE, OP_STX_ABS, 8'h00, 8'h00, 8'h00}},
            '{X_VALUE, 1'b0, 16'h0000, 3'd3, {OP_STX_ABS, 8'h01, 8'h00, 24'h0}},
            '{Y_VALUE, 1'b0, 16'h0000, 3'd5,
              {OP_LDY_IMM, Y_VALUE, OP_STY_ABS, 8'h02, 8'h00, 8'h00}},
            '{Y_VALUE, 1'b0, 16'h0000, 3'd3, {OP_STY_ABS, 8'h03, 8'h00, 24'h0}},
            '{8'hFF, 1'b0, 16'h0000, 3'd5,
              {OP_LDA_IMM, 8'hFF, OP_STA_ABS, 8'h04, 8'h00, 8'h00}},
            '{8'hFF, 1'b0, 16'h0000, 3'd3, {OP_STA_ABS, 8'h05, 8'h00, 24'h0}},
            '{8'h01, 1'b0, 16'h0000, 3'd5,
              {OP_LDA_IMM, 8'h01, OP_STA_ABS, 8'h06, 8'h00, 8'h00}},
            '{8'hFF, 1'b1, 16'hFFFF, 3'd5,
              {OP_LDA_IMM, 8'hFF, OP_STA_ABS, 8'hFF, 8'hFF, 8'h00}},
            '{8'hFF, 1'b0, 16'h0000, 3'd3, {OP_STA_ABS, 8'h00, 8'h00, 24'h0}},
            '{X_VALUE, 1'b1, 16'h0000, 3'd5,
              {OP_LDX_IMM, X_VALUE, OP_STX_ABS, 8'h00, 8'h00, 8'h00}},
            '{Y_VALUE, 1'b1, 16'h1234, 3'd5,
              {OP_LDY_IMM, Y_VALUE, OP_STY_ABS, 8'h34, 8'h12, 8'h00}},
            '{8'h7F, 1'b0, 16'h0000, 3'd5,
              {OP_LDA_IMM, 8'h7F, OP_STA_ABS, 8'h35, 8'h12, 8'h00}},
            '{Y_VALUE, 1'b0, 16'h0000, 3'd3, {OP_STY_ABS, 8'h36, 8'h12, 24'h0}},
            '{8'h7F, 1'b0, 16'h0000, 3'd3, {OP_STA_ABS, 8'h37, 8'h12, 24'h0}},
            '{X_VALUE, 1'b0, 16'h0000, 3'd5,
              {OP_LDX_IMM, X_VALUE, OP_STX_ABS, 8'h38, 8'h12, 8'h00}},
            '{8'h01, 1'b1, 16'h5555, 3'd5,
              {OP_LDA_IMM, 8'h01, OP_STA_ABS, 8'h55, 8'h55, 8'h00}},
            '{8'h02, 1'b0, 16'h0000, 3'd5,
              {OP_LDA_IMM, 8'h02, OP_STA_ABS, 8'h56, 8'h55, 8'h00}},
            '{8'h01, 1'b0, 16'h0000, 3'd5,
              {OP_LDA_IMM, 8'h01, OP_STA_ABS, 8'h57, 8'h55, 8'h00}},
            '{8'hAA, 1'b1, 16'hAAAA, 3'd5,
              {OP_LDA_IMM, 8'hAA, OP_STA_ABS, 8'hAA, 8'hAA, 8'h00}},
            '{X_VALUE, 1'b1, 16'h8000, 3'd5,
              {OP_LDX_IMM, X_VALUE, OP_STX_ABS, 8'h00, 8'h80, 8'h00}},
            '{Y_VALUE, 1'b0, 16'h0000, 3'd5,
              {OP_LDY_IMM, Y_VALUE, OP_STY_ABS, 8'h01, 8'h80, 8'h00}},
            '{8'h55, 1'b0, 16'hFFFF, 3'd5,
              {OP_LDA_IMM, 8'h55, OP_STA_ABS, 8'h02, 8'h80, 8'h00}},
            '{X_VALUE, 1'b1, 16'h00FF, 3'd5,
              {OP_LDX_IMM, X_VALUE, OP_STX_ABS, 8'hFF, 8'h00, 8'h00}},
            '{X_VALUE, 1'b0, 16'h0000, 3'd0, 48'h0},
            '{Y_VALUE, 1'b1, 16'h7FFF, 3'd0, 48'h0}
        };
        mismatches    = 0;
        items_taken   = 0;
        burst_left    = $urandom_range(1, 16);
        last_imm      = 8'h42;
        tgt_addr      = 16'h0000;
        page_cnt      = 0;
        clear_loads();
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        data_byte     = 8'h00;
        block_start   = 1'b0;
        start_address = 16'h0000;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            offer(dir_rows[i].data, dir_rows[i].bs, dir_rows[i].addr,
                  dir_rows[i].n, dir_rows[i].codes);

        for (int i = 0; i < 95; i++)
        begin
            d = pick_data();
            a = 16'($urandom_range(0, 65535));
            offer(d, $urandom_range(0, 9) == 0, a, 3'd0, 48'h0);
        end
        in_valid <= 1'b0;

        while (code_expect.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: filelist.f
design/scg_pkg.sv
design/scg_front.sv
design/scg_queue.sv
design/scg_back.sv
design/store_code_generator.sv
tb/store_code_generator_tb.sv
